### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/obd_reasm_pkg.sv
// ----------------------------------------------------------------------------
// OBD reassembler package
// Codes, command and status types shared by the reassembler modules.
// ----------------------------------------------------------------------------
package obd_reasm_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam int MAX_WORDS        = 16;

  localparam logic       OP_REQUEST    = 1'b0;
  localparam logic [3:0] DLC_FULL      = 4'd8;
  localparam logic [7:0] FRAME_BYTES   = 8'd8;
  localparam logic [7:0] RESP_ID_OFS   = 8'h08;
  localparam logic [7:0] PCI_FIRST     = 8'h10;
  localparam logic [7:0] PCI_FLOW      = 8'h30;
  localparam logic [7:0] SEQ_FIRST     = 8'h21;
  localparam logic [7:0] MODE_RESP_OFS = 8'h40;
  localparam logic [7:0] PCI_REQ_LEN   = 8'h02;
  localparam logic [7:0] SF_MIN        = 8'd2;
  localparam logic [7:0] SF_MAX        = 8'd7;
  localparam logic [7:0] FF_INLINE     = 8'd6;
  localparam logic [7:0] CF_MAX_BYTES  = 8'd7;

  typedef enum logic [2:0] {
    KIND_REQUEST = 3'd0,
    KIND_FLOW    = 3'd1,
    KIND_RAW     = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_SEQUENCE = 3'd2,
    ERR_MODE     = 3'd3,
    ERR_PID      = 3'd4,
    ERR_TYPE     = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    ACT_REQ,
    ACT_RAW,
    ACT_ERR,
    ACT_FF,
    ACT_SF,
    ACT_CF
  } act_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_FIRST,
    WR_CF_LO,
    WR_CF_HI
  } wr_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CF_HI,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    apply;
    wr_sel_t wr_sel;
    logic    load_single;
    logic    load_word;
    logic    close;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic out_free;
    logic cf_done;
    logic last_word;
  } status_t;

endpackage

### hw/rtl/obd_reasm_ctrl.sv
// ----------------------------------------------------------------------------
// OBD reassembler controller
// Sequences decode, payload store writes and result emission.
// ----------------------------------------------------------------------------
module obd_reasm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  obd_reasm_pkg::status_t stat,
  output obd_reasm_pkg::cmd_t    cmd
);
  import obd_reasm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (stat.act) inside
          ACT_REQ, ACT_RAW, ACT_ERR, ACT_FF: begin
            if (stat.out_free) state_next = ST_IDLE;
          end
          ACT_SF: state_next = ST_EMIT_RD;
          ACT_CF: state_next = ST_CF_HI;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_CF_HI: begin
        state_next = stat.cf_done ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (stat.out_free && stat.last_word) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        // Hold off transfers while reset is applied.
        in_ready  = !rst;
        cmd.latch = in_valid && !rst;
      end
      ST_DECIDE: begin
        unique case (stat.act) inside
          ACT_REQ: begin
            cmd.load_single = stat.out_free;
            cmd.apply       = stat.out_free;
          end
          ACT_RAW, ACT_ERR: begin
            cmd.load_single = stat.out_free;
          end
          ACT_FF: begin
            cmd.load_single = stat.out_free;
            cmd.apply       = stat.out_free;
            cmd.wr_sel      = stat.out_free ? WR_FIRST : WR_NONE;
          end
          ACT_SF: begin
            cmd.apply  = 1'b1;
            cmd.wr_sel = WR_FIRST;
          end
          ACT_CF: begin
            cmd.wr_sel = WR_CF_LO;
          end
          default: cmd = '0;
        endcase
      end
      ST_CF_HI: begin
        cmd.wr_sel = WR_CF_HI;
        cmd.apply  = 1'b1;
      end
      ST_EMIT_RD: cmd = '0;
      ST_EMIT_LD: begin
        cmd.load_word = stat.out_free;
        cmd.close     = stat.out_free && stat.last_word;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### hw/rtl/obd_reasm_dp.sv
// ----------------------------------------------------------------------------
// OBD reassembler datapath
// Input capture, session registers, payload store and result register.
// ----------------------------------------------------------------------------
module obd_reasm_dp #(
  parameter int BUFFER_BYTES = obd_reasm_pkg::BUFFER_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  obd_reasm_pkg::cmd_t    cmd,
  output obd_reasm_pkg::status_t stat,
  input  logic                   operation,
  input  logic [10:0]            request_addr,
  input  logic [15:0]            request_mode_pid,
  input  logic [10:0]            frame_id,
  input  logic [3:0]             frame_len,
  input  logic [63:0]            frame_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             kind,
  output logic [10:0]            tx_id,
  output logic [63:0]            word,
  output logic [7:0]             byte_count,
  output logic [2:0]             error_code,
  output logic                   last
);
  import obd_reasm_pkg::*;

  localparam int ROWS  = (BUFFER_BYTES + 7) / 8;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // captured item
  logic        op_q;
  logic [10:0] req_addr_q;
  logic [15:0] req_mp_q;
  logic [10:0] fid_q;
  logic [3:0]  flen_q;
  logic [63:0] fdata_q;

  // session state
  logic        waiting;
  logic [10:0] target_addr;
  logic [15:0] expected_mode_pid;
  logic [7:0]  total_len;
  logic [7:0]  fill_offset;
  logic [7:0]  next_seq;
  logic [4:0]  word_idx;

  // payload store
  logic [63:0]     mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [63:0]     rd_q;
  logic            rd_ok;

  logic [7:0]   b0, b1, b2, b3;
  logic [8:0]   want_mode;
  logic [11:0]  resp_id;
  logic         id_match;
  act_t         act;
  err_t         err_sel;
  logic [7:0]   remaining;
  logic [2:0]   cf_n;
  logic [7:0]   cf_fill_next;
  logic [6:0]   cf_mask;
  logic [15:0]  cf_be;
  logic [127:0] cf_shift;

  logic [5:0]  wr_row;
  logic [7:0]  wr_be;
  logic [63:0] wr_data;
  logic [7:0]  lane_ok;
  logic [7:0]  be_ok;
  logic [7:0]  be_eff;
  logic [63:0] d_eff;
  logic        wr_en;
  logic        fresh;
  logic [ROW_W-1:0] wr_idx;

  logic [4:0]       rd_j;
  logic [ROW_W-1:0] rd_idx;
  logic             rd_hit;
  logic [8:0]       avail;
  logic [5:0]       words_raw;
  logic [5:0]       words;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q       <= operation;
      req_addr_q <= request_addr;
      req_mp_q   <= request_mode_pid;
      fid_q      <= frame_id;
      flen_q     <= frame_len;
      fdata_q    <= frame_data;
    end
  end

  // Decode the held item against the session.
  assign b0 = fdata_q[7:0];
  assign b1 = fdata_q[15:8];
  assign b2 = fdata_q[23:16];
  assign b3 = fdata_q[31:24];
  assign want_mode = {1'b0, MODE_RESP_OFS} + {1'b0, expected_mode_pid[15:8]};
  assign resp_id   = {1'b0, target_addr} + {4'd0, RESP_ID_OFS};
  assign id_match  = waiting && ({1'b0, fid_q} == resp_id);

  always_comb begin
    act     = ACT_RAW;
    err_sel = ERR_NONE;
    if (op_q == OP_REQUEST) begin
      act = ACT_REQ;
    end else if (!id_match) begin
      act = ACT_RAW;
    end else if (flen_q != DLC_FULL) begin
      act     = ACT_ERR;
      err_sel = ERR_LENGTH;
    end else if (total_len > fill_offset) begin
      if (b0 != next_seq) begin
        act     = ACT_ERR;
        err_sel = ERR_SEQUENCE;
      end else begin
        act = ACT_CF;
      end
    end else if (b0 == PCI_FIRST) begin
      if ({1'b0, b2} != want_mode) begin
        act     = ACT_ERR;
        err_sel = ERR_MODE;
      end else if (b3 != expected_mode_pid[7:0]) begin
        act     = ACT_ERR;
        err_sel = ERR_PID;
      end else begin
        act = ACT_FF;
      end
    end else if (b0 >= SF_MIN && b0 <= SF_MAX) begin
      if ({1'b0, b1} != want_mode) begin
        act     = ACT_ERR;
        err_sel = ERR_MODE;
      end else if (b2 != expected_mode_pid[7:0]) begin
        act     = ACT_ERR;
        err_sel = ERR_PID;
      end else begin
        act = ACT_SF;
      end
    end else begin
      act     = ACT_ERR;
      err_sel = ERR_TYPE;
    end
  end

  // Consecutive frame: up to seven bytes at the fill offset, may straddle two rows.
  assign remaining    = total_len - fill_offset;
  assign cf_n         = (remaining > CF_MAX_BYTES) ? CF_MAX_BYTES[2:0] : remaining[2:0];
  assign cf_fill_next = fill_offset + {5'd0, cf_n};
  assign cf_mask      = 7'((8'd1 << cf_n) - 8'd1);
  assign cf_be        = {9'd0, cf_mask} << fill_offset[2:0];
  assign cf_shift     = {72'd0, fdata_q[63:8]} << {fill_offset[2:0], 3'b000};

  always_comb begin
    wr_row  = 6'd0;
    wr_be   = 8'd0;
    wr_data = 64'd0;
    case (cmd.wr_sel)
      WR_FIRST: begin
        if (act == ACT_SF) begin
          wr_data = fdata_q >> 8;
          wr_be   = 8'((9'd1 << b0[2:0]) - 9'd1);
        end else begin
          wr_data = fdata_q >> 16;
          wr_be   = 8'h3F;
        end
      end
      WR_CF_LO: begin
        wr_row  = {1'b0, fill_offset[7:3]};
        wr_data = cf_shift[63:0];
        wr_be   = cf_be[7:0];
      end
      WR_CF_HI: begin
        wr_row  = {1'b0, fill_offset[7:3]} + 6'd1;
        wr_data = cf_shift[127:64];
        wr_be   = cf_be[15:8];
      end
      default: wr_row = 6'd0;
    endcase
  end

  // Drop bytes that fall past the end of the store.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lane_ok[k] = ({wr_row, 3'(k)} < 9'(BUFFER_BYTES));
    end
  end

  assign be_ok  = wr_be & lane_ok;
  assign wr_en  = (cmd.wr_sel != WR_NONE) && (|be_ok);
  assign wr_idx = wr_row[ROW_W-1:0];
  assign fresh  = (cmd.wr_sel == WR_FIRST) || !row_valid[wr_idx];
  assign be_eff = fresh ? 8'hFF : be_ok;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      d_eff[8*k +: 8] = be_ok[k] ? wr_data[8*k +: 8] : 8'h00;
    end
  end

  // Read the row for the word being emitted, or the next one while loading.
  assign rd_j   = cmd.load_word ? word_idx + 5'd1 : word_idx;
  assign rd_idx = rd_j[ROW_W-1:0];
  assign rd_hit = ({1'b0, rd_j} < 6'(ROWS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < 8; k++) begin
        if (be_eff[k]) mem[wr_idx][8*k +: 8] <= d_eff[8*k +: 8];
      end
    end
    rd_q  <= mem[rd_idx];
    rd_ok <= rd_hit && row_valid[rd_idx];
  end

  // A first write always lands in row 0: drop every other row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.wr_sel == WR_FIRST) begin
      row_valid <= ROWS'(wr_en);
    end else if (wr_en) begin
      row_valid[wr_idx] <= 1'b1;
    end
  end

  // Word count covers min(total, store size), capped at the word limit.
  assign avail     = ({1'b0, total_len} > 9'(BUFFER_BYTES)) ? 9'(BUFFER_BYTES)
                                                          : {1'b0, total_len};
  assign words_raw = 6'((avail + 9'd7) >> 3);
  assign words     = (words_raw > 6'(MAX_WORDS)) ? 6'(MAX_WORDS) : words_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting           <= 1'b0;
      target_addr       <= '0;
      expected_mode_pid <= '0;
      total_len         <= '0;
      fill_offset       <= '0;
      next_seq          <= '0;
      word_idx          <= '0;
    end else begin
      if (cmd.latch) word_idx <= '0;
      else if (cmd.load_word) word_idx <= word_idx + 5'd1;
      if (cmd.close) waiting <= 1'b0;
      if (cmd.apply) begin
        case (act)
          ACT_REQ: begin
            waiting           <= 1'b1;
            target_addr       <= req_addr_q;
            expected_mode_pid <= req_mp_q;
            total_len         <= '0;
            fill_offset       <= '0;
            next_seq          <= '0;
          end
          ACT_FF: begin
            total_len   <= b1;
            fill_offset <= FF_INLINE;
            next_seq    <= SEQ_FIRST;
          end
          ACT_SF: begin
            total_len   <= b0;
            fill_offset <= b0;
          end
          ACT_CF: begin
            fill_offset <= cf_fill_next;
            next_seq    <= next_seq + 8'd1;
          end
          default: waiting <= waiting;
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_word) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      kind       <= KIND_PAYLOAD;
      tx_id      <= fid_q;
      word       <= rd_ok ? rd_q : 64'd0;
      byte_count <= total_len;
      error_code <= ERR_NONE;
      last       <= stat.last_word;
    end else if (cmd.load_single) begin
      last <= 1'b1;
      case (act)
        ACT_REQ: begin
          kind       <= KIND_REQUEST;
          tx_id      <= req_addr_q;
          word       <= {40'd0, req_mp_q[7:0], req_mp_q[15:8], PCI_REQ_LEN};
          byte_count <= FRAME_BYTES;
          error_code <= ERR_NONE;
        end
        ACT_FF: begin
          kind       <= KIND_FLOW;
          tx_id      <= target_addr;
          word       <= {56'd0, PCI_FLOW};
          byte_count <= FRAME_BYTES;
          error_code <= ERR_NONE;
        end
        ACT_ERR: begin
          kind       <= KIND_ERROR;
          tx_id      <= fid_q;
          word       <= fdata_q;
          byte_count <= {4'd0, flen_q};
          error_code <= err_sel;
        end
        default: begin
          kind       <= KIND_RAW;
          tx_id      <= fid_q;
          word       <= fdata_q;
          byte_count <= {4'd0, flen_q};
          error_code <= ERR_NONE;
        end
      endcase
    end
  end

  assign stat.act       = act;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.cf_done   = (cf_fill_next == total_len);
  assign stat.last_word = (({1'b0, word_idx} + 6'd1) == words);

endmodule

### hw/rtl/obd_isotp_request_reassembler.sv
// ----------------------------------------------------------------------------
// OBD-II request / ISO-TP response reassembler
// Issues diagnostic requests and reassembles the answering frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries either a request start
//   (operation 0: target id, mode/PID) or a received CAN frame (operation 1).
//   Output channel (out_valid/out_ready) carries result transfers: request
//   frame, flow control frame, raw passthrough, payload words or an error.
//   last marks the final result caused by an input transfer; a consecutive
//   frame that does not finish the answer causes no result at all.
// Timing:
//   One item at a time. A single-result item loads its result in the decide
//   state, which waits while the result register is full; in_ready returns
//   as the result is presented. A completing frame emits ceil(min(total,
//   BUFFER_BYTES)/8) words (at most 16) after its store writes (decide,
//   plus high row for a consecutive frame), a read state and a load state,
//   one word per cycle while the receiver takes them, the rate of the
//   single store read port. in_ready returns after the last word.
// Reset: clears the session (no request open) and the store row valid
//   bits, so unwritten store bytes read as zero; in_ready stays low.
// Stall: a stalled receiver holds the result register; the controller
//   waits and loses nothing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obd_isotp_request_reassembler #(
  parameter int BUFFER_BYTES = obd_reasm_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [10:0] request_addr,
  input  logic [15:0] request_mode_pid,
  input  logic [10:0] frame_id,
  input  logic [3:0]  frame_len,
  input  logic [63:0] frame_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [10:0] tx_id,
  output logic [63:0] word,
  output logic [7:0]  byte_count,
  output logic [2:0]  error_code,
  output logic        last
);
  import obd_reasm_pkg::*;

  cmd_t    cmd;
  status_t stat;
  logic    res_load;

  // Controller: decides, sequences store writes and word emission.
  obd_reasm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: item capture, session registers, store and result register.
  obd_reasm_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .request_addr     (request_addr),
    .request_mode_pid (request_mode_pid),
    .frame_id         (frame_id),
    .frame_len        (frame_len),
    .frame_data       (frame_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .tx_id            (tx_id),
    .word             (word),
    .byte_count       (byte_count),
    .error_code       (error_code),
    .last             (last)
  );

  assign res_load = cmd.load_single || cmd.load_word;

  // Load the result register only when it is free or being drained.
  `ASSERT_IMPLIES(a_load_free, clk, rst, res_load, stat.out_free, "load while full")
  // Never write the store while accepting a new item.
  `ASSERT_IMPLIES(a_idle_no_write, clk, rst, in_ready, cmd.wr_sel == WR_NONE, "write while idle")
  // Close the session only on the final payload word.
  `ASSERT_IMPLIES(a_close_last, clk, rst, cmd.close, cmd.load_word && stat.last_word, "early close")
  // A loaded result shows up as valid in the next cycle.
  `ASSERT_NEXT(a_load_valid, clk, rst, res_load, out_valid, "result not presented")

endmodule
